@@ sv/ipv6_text_formatter_core_macros.svh @@
// Assertion macros shared by the IPv6 text formatter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef IPV6_TEXT_FORMATTER_CORE_MACROS_SVH
`define IPV6_TEXT_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define IPV6F_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define IPV6F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ipv6f_pkg.sv @@
// Types, constants and helpers for the IPv6 text formatter.
// No dependencies; used by every module of the block by scoped names.
package ipv6f_pkg;

    localparam int NUM_GROUPS = 8;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    // 'a' minus ten, so that nibble values 10..15 map onto 'a'..'f'
    localparam logic [7:0] CHAR_A_OFS = 8'h57;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_in_item;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_out_item;

    // Classified address, handed from the front to the emitter
    typedef struct packed {
        logic [7:0][15:0] groups;     // group 0 is the most significant
        logic [7:0][1:0]  ndig_m1;    // printed digit count minus one
        logic             comp;       // a run of two or more zero groups exists
        logic [2:0]       run_start;  // first group of the compressed run
        logic [3:0]       run_end;    // one past the last group of the run
    } t_desc;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CHAR_ZERO + {4'd0, nib};
        end else begin
            ch = CHAR_A_OFS + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

@@ sv/ipv6f_front.sv @@
// Front stage of the IPv6 text formatter: splits the address into groups,
// counts digits and finds the zero run to compress. Depends on ipv6f_pkg.
`include "ipv6_text_formatter_core_macros.svh"

module ipv6f_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ipv6f_pkg::t_in_item i_in,
    output logic              o_push,
    output ipv6f_pkg::t_desc  o_desc,
    input  logic              i_q_ready
);

    ipv6f_pkg::t_desc c_desc;
    ipv6f_pkg::t_desc r_desc;
    logic             r_valid;
    logic             n_valid;
    logic             w_accept;

    logic [3:0] cur_len;
    logic [2:0] zero_start;
    logic [3:0] top_len;
    logic [2:0] top_start;

    // Split into groups and count printed digits per group
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            c_desc.groups[i]     = i_in.addr_high[63 - 16 * i -: 16];
            c_desc.groups[i + 4] = i_in.addr_low[63 - 16 * i -: 16];
        end
        for (int i = 0; i < ipv6f_pkg::NUM_GROUPS; i++) begin
            if (c_desc.groups[i][15:12] != 4'd0) begin
                c_desc.ndig_m1[i] = 2'd3;
            end else if (c_desc.groups[i][11:8] != 4'd0) begin
                c_desc.ndig_m1[i] = 2'd2;
            end else if (c_desc.groups[i][7:4] != 4'd0) begin
                c_desc.ndig_m1[i] = 2'd1;
            end else begin
                c_desc.ndig_m1[i] = 2'd0;
            end
        end
        // Scan for the longest zero run, earliest wins on a tie
        cur_len    = 4'd0;
        zero_start = 3'd0;
        top_len    = 4'd0;
        top_start  = 3'd0;
        for (int i = 0; i < ipv6f_pkg::NUM_GROUPS; i++) begin
            if (c_desc.groups[i] == 16'd0) begin
                if (cur_len == 4'd0) begin
                    zero_start = 3'(i);
                end
                cur_len = cur_len + 4'd1;
                if (cur_len > top_len) begin
                    top_len   = cur_len;
                    top_start = zero_start;
                end
            end else begin
                cur_len = 4'd0;
            end
        end
        c_desc.comp      = (top_len >= 4'd2);
        c_desc.run_start = top_start;
        c_desc.run_end   = {1'b0, top_start} + top_len;
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Hold the classified item until the queue takes it
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (r_valid && i_q_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_desc <= c_desc;
        end
    end

    assign o_push = r_valid;
    assign o_desc = r_desc;

    `IPV6F_ASSERT_NOW(a_run_len, i_clk, i_rst_n, r_valid && r_desc.comp,
        ({1'b0, r_desc.run_start} + 4'd2 <= r_desc.run_end) && (r_desc.run_end <= 4'd8),
        "compressed run shorter than two groups or past the end")
    `IPV6F_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !i_q_ready,
        r_valid && $stable(r_desc), "stalled front item changed")

endmodule

@@ sv/ipv6f_fifo.sv @@
// Short show-ahead queue between the front and the emitter.
// Depends on ipv6f_pkg for the descriptor type.
`include "ipv6_text_formatter_core_macros.svh"

module ipv6f_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ipv6f_pkg::t_desc i_data,
    output logic             o_ready,
    output logic             o_valid,
    output ipv6f_pkg::t_desc o_data,
    input  logic             i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ipv6f_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `IPV6F_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
        "queue occupancy exceeds depth")
    `IPV6F_ASSERT_NOW(a_pop_empty, i_clk, i_rst_n, i_pop, o_valid,
        "pop from empty queue")

endmodule

@@ sv/ipv6f_emit.sv @@
// Back stage of the IPv6 text formatter: walks one classified address and
// issues one character per ready cycle to an output register. Uses ipv6f_pkg.
`include "ipv6_text_formatter_core_macros.svh"

module ipv6f_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  ipv6f_pkg::t_desc     i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ipv6f_pkg::t_out_item o_out
);

    logic [2:0]  r_grp;
    logic [2:0]  r_sub;
    logic [2:0]  n_grp;
    logic [2:0]  n_sub;
    logic        r_out_valid;
    ipv6f_pkg::t_out_item r_out;

    logic        w_adv;
    logic        w_last;
    logic [7:0]  w_char;
    logic [15:0] w_group;
    logic [1:0]  w_ndm1;
    logic [1:0]  w_nib_idx;
    logic        w_in_run;
    logic        w_sep;

    assign w_adv     = i_head_valid && (!r_out_valid || i_out_ready);
    assign w_group   = i_head.groups[r_grp];
    assign w_ndm1    = i_head.ndig_m1[r_grp];
    assign w_nib_idx = w_ndm1 - r_sub[1:0];
    assign w_in_run  = i_head.comp && (r_grp == i_head.run_start);
    // A separator follows unless this is the last group or the run comes next
    assign w_sep     = (r_grp != 3'd7) &&
                       !(i_head.comp && ({1'b0, r_grp} + 4'd1 == {1'b0, i_head.run_start}));

    // Pick the character and the next walk position
    always_comb begin
        w_char = ipv6f_pkg::CHAR_COLON;
        w_last = 1'b0;
        n_grp  = r_grp;
        n_sub  = r_sub + 3'd1;
        if (w_in_run) begin
            if (r_sub != 3'd0) begin
                n_grp  = i_head.run_end[2:0];
                n_sub  = 3'd0;
                w_last = (i_head.run_end == 4'd8);
            end
        end else if (r_sub <= {1'b0, w_ndm1}) begin
            w_char = ipv6f_pkg::hex_char(w_group[{w_nib_idx, 2'b00} +: 4]);
            if (r_sub == {1'b0, w_ndm1} && !w_sep) begin
                n_grp  = r_grp + 3'd1;
                n_sub  = 3'd0;
                w_last = (r_grp == 3'd7);
            end
        end else begin
            n_grp = r_grp + 3'd1;
            n_sub = 3'd0;
        end
        if (w_last) begin
            n_grp = 3'd0;
            n_sub = 3'd0;
        end
    end

    assign o_pop = w_adv && w_last;

    // Advance the walk and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp       <= 3'd0;
            r_sub       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_grp       <= n_grp;
                r_sub       <= n_sub;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out.text_char <= w_char;
            r_out.last_char <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `IPV6F_ASSERT_NEXT(a_restart, i_clk, i_rst_n, w_adv && w_last,
        (r_grp == 3'd0) && (r_sub == 3'd0), "walk did not restart after last character")
    `IPV6F_ASSERT_NOW(a_sub_range, i_clk, i_rst_n, 1'b1, r_sub <= 3'd4,
        "character position within group out of range")

endmodule

@@ sv/ipv6_text_formatter_core.sv @@
// IPv6 text formatter top level: RFC 5952 canonical text, one character a cycle
// unless stalled. Depends on ipv6f_pkg, ipv6f_front, ipv6f_fifo and ipv6f_emit.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one 128-bit address
//   as two 64-bit halves. Output channel (o_out_valid / i_out_ready / o_out)
//   gives the text one ASCII character per transfer, last_char set on the
//   final character; no terminator is sent.
//   With the front and the queue empty, the first character of an address
//   passes the front register, a queue entry and the output register.
//   Each address has 2 to 39 characters, issued by the emitter one character
//   per cycle while the receiver is ready. The front classifies into a register
//   and up to QUEUE_DEPTH addresses wait between the front and the emitter,
//   so addresses stream with no gap between texts.
//   Reset (i_rst_n low, synchronous) empties the queue and both stages.
//   When the receiver stalls, the current character holds in the output
//   register; the queue fills and then o_in_ready drops.
module ipv6_text_formatter_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ipv6f_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ipv6f_pkg::t_out_item o_out
);

    logic             w_push;
    logic             w_q_ready;
    ipv6f_pkg::t_desc w_push_desc;
    logic             w_head_valid;
    ipv6f_pkg::t_desc w_head;
    logic             w_pop;

    // Classify incoming addresses
    ipv6f_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_push     (w_push),
        .o_desc     (w_push_desc),
        .i_q_ready  (w_q_ready)
    );

    // Decouple front and emitter
    ipv6f_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_desc),
        .o_ready (w_q_ready),
        .o_valid (w_head_valid),
        .o_data  (w_head),
        .i_pop   (w_pop)
    );

    // Emit characters
    ipv6f_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
